// ----- hdl/tced_pkg.sv -----
// ----------------------------------------------------------------------------
// tced_pkg: shared types and constants of the capability string decoder
// Holds the result item type, decode mode codes, character codes and the
// backslash escape table.
// ----------------------------------------------------------------------------
package tced_pkg;

  // Decode mode codes.
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_CARET  = 2'd1;
  localparam logic [1:0] MODE_BSLASH = 2'd2;
  localparam logic [1:0] MODE_OCTAL  = 2'd3;

  // Character codes seen by the decoder.
  localparam logic [7:0] CHR_NUL    = 8'h00;
  localparam logic [7:0] CHR_COLON  = 8'h3A;
  localparam logic [7:0] CHR_CARET  = 8'h5E;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_QMARK  = 8'h3F;
  localparam logic [7:0] CHR_DEL    = 8'h7F;
  localparam logic [7:0] CTRL_MASK  = 8'h1F;
  localparam logic [7:0] OCT_ZERO   = 8'h80;

  // Output queue geometry.
  localparam int QDEPTH = 4;
  localparam int QPTRW  = $clog2(QDEPTH);
  localparam int QCNTW  = $clog2(QDEPTH + 1);

  // One decoded result item.
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       last;
  } result_t;

  // Results of one decode step, handed to the output queue.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Octal digit test: '0' through '7'.
  function automatic logic is_octal(input logic [7:0] b);
    return b[7:3] == 5'b00110;
  endfunction

  // Control code for the byte after a backslash; other bytes pass unchanged.
  function automatic logic [7:0] esc_map(input logic [7:0] b);
    logic [7:0] v;
    v = b;
    case (b)
      8'h45, 8'h65: v = 8'h1B;  // E, e
      8'h73:        v = 8'h20;  // s
      8'h6C, 8'h6E: v = 8'h0A;  // l, n
      8'h72:        v = 8'h0D;  // r
      8'h74:        v = 8'h09;  // t
      8'h61:        v = 8'h07;  // a
      8'h62:        v = 8'h08;  // b
      8'h66:        v = 8'h0C;  // f
      8'h76:        v = 8'h0B;  // v
      default:      v = b;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/tced_core.sv -----
// ----------------------------------------------------------------------------
// tced_core: input register and decode step
// Registers the incoming byte, then decodes it against the mode, octal value
// and digit count, producing zero, one or two results per byte.
// ----------------------------------------------------------------------------
module tced_core
  import tced_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       room2,
  output push_t      push
);

  logic       held;
  logic [7:0] held_byte;
  logic       advance;

  logic [1:0] mode, mode_next;
  logic [7:0] oval, oval_next;
  logic [1:0] odig, odig_next;

  logic [7:0] b;
  logic       nm_emit;
  logic [7:0] nm_data;
  logic       nm_eos;
  logic [1:0] nm_mode;
  logic       nm_end;
  push_t      res;

  assign advance  = held && room2;
  assign in_ready = !held || advance;
  assign b        = held_byte;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
    end
  end

  // Plain-mode handling of the byte, also used after a finished octal run.
  always_comb begin
    nm_emit = 1'b0;
    nm_data = b;
    nm_eos  = 1'b0;
    nm_mode = MODE_NORMAL;
    nm_end  = 1'b0;
    if (b == CHR_NUL || b == CHR_COLON) begin
      nm_emit = 1'b1;
      nm_data = CHR_NUL;
      nm_eos  = 1'b1;
      nm_end  = 1'b1;
    end else if (b == CHR_CARET) begin
      nm_mode = MODE_CARET;
    end else if (b == CHR_BSLASH) begin
      nm_mode = MODE_BSLASH;
    end else begin
      nm_emit = 1'b1;
    end
  end

  // Decode step.
  always_comb begin
    mode_next = mode;
    oval_next = oval;
    odig_next = odig;
    res       = '0;
    unique case (mode)
      MODE_NORMAL: begin
        mode_next   = nm_mode;
        res.count   = {1'b0, nm_emit};
        res.r0.data = nm_data;
        res.r0.eos  = nm_eos;
        if (nm_end) begin
          oval_next = '0;
          odig_next = '0;
        end
      end
      MODE_CARET: begin
        res.count = 2'd1;
        mode_next = MODE_NORMAL;
        if (b == CHR_NUL) begin
          res.r0.eos = 1'b1;
          oval_next  = '0;
          odig_next  = '0;
        end else begin
          res.r0.data = (b == CHR_QMARK) ? CHR_DEL : (b & CTRL_MASK);
        end
      end
      MODE_BSLASH: begin
        if (b == CHR_NUL) begin
          res.count  = 2'd1;
          res.r0.eos = 1'b1;
          mode_next  = MODE_NORMAL;
          oval_next  = '0;
          odig_next  = '0;
        end else if (is_octal(b)) begin
          mode_next = MODE_OCTAL;
          oval_next = {5'd0, b[2:0]};
          odig_next = 2'd1;
        end else begin
          res.count   = 2'd1;
          res.r0.data = esc_map(b);
          mode_next   = MODE_NORMAL;
        end
      end
      MODE_OCTAL: begin
        if (b == CHR_NUL) begin
          // Collected value is dropped; only the terminator goes out.
          res.count  = 2'd1;
          res.r0.eos = 1'b1;
          mode_next  = MODE_NORMAL;
          oval_next  = '0;
          odig_next  = '0;
        end else if (is_octal(b) && odig != 2'd3) begin
          oval_next = {oval[4:0], b[2:0]};
          odig_next = odig + 2'd1;
        end else begin
          // Flush the octal value, then treat the byte as plain input.
          res.r0.data = (oval == 8'd0) ? OCT_ZERO : oval;
          res.r1.data = nm_data;
          res.r1.eos  = nm_eos;
          res.count   = nm_emit ? 2'd2 : 2'd1;
          mode_next   = nm_mode;
          oval_next   = '0;
          odig_next   = '0;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
      end
    endcase
    res.r0.last = (res.count == 2'd1);
    res.r1.last = (res.count == 2'd2);
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      oval <= '0;
      odig <= '0;
    end else if (advance) begin
      mode <= mode_next;
      oval <= oval_next;
      odig <= odig_next;
    end
  end

  always_comb begin
    push = res;
    if (!advance) begin
      push.count = 2'd0;
    end
  end

endmodule

// ----- hdl/tced_outq.sv -----
// ----------------------------------------------------------------------------
// tced_outq: output result queue
// Small queue that takes up to two results per cycle and delivers one result
// per cycle on the output handshake.
// ----------------------------------------------------------------------------
module tced_outq
  import tced_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  output logic             room2,
  output logic             out_valid,
  input  logic             out_ready,
  output result_t          head,
  output logic [QCNTW-1:0] level
);

  result_t              mem [QDEPTH];
  logic [QPTRW-1:0]     wr_ptr;
  logic [QPTRW-1:0]     rd_ptr;
  logic [QCNTW-1:0]     count;
  logic [QCNTW-1:0]     count_next;
  logic                 pop;
  logic [QPTRW-1:0]     wr_ptr1;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign head      = mem[rd_ptr];
  assign room2     = count <= QCNTW'(QDEPTH - 2);
  assign level     = count;
  assign wr_ptr1   = wr_ptr + QPTRW'(1);

  assign count_next = count + QCNTW'(push.count) - QCNTW'(pop);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTRW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTRW'(1);
      end
      count <= count_next;
    end
  end

endmodule

// ----- hdl/termcap_escape_decoder_unit.sv -----
// A byte is registered at acceptance; its results enter the output queue once
// the queue has room for two, and the queue head drives the outputs.
// Throughput: one byte per cycle while the queue has room for two; a byte with
// two results holds the single output port for both; it sets the sustained rate.
// Reset (rst, synchronous, active high) returns to normal mode with no pending
// octal value and empties the input register and the result queue.
// ----------------------------------------------------------------------------
// termcap_escape_decoder_unit: capability string escape decoder
// Decodes caret, backslash and octal escapes of a byte stream and marks the
// terminating zero byte or colon of each string with a zero result.
// ----------------------------------------------------------------------------
module termcap_escape_decoder_unit
  import tced_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       end_of_string,
  output logic       last_of_run
);

  push_t            push;
  logic             room2;
  result_t          head;
  logic [QCNTW-1:0] level;

  // Byte register and decode step.
  tced_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .room2    (room2),
    .push     (push)
  );

  // Result queue.
  tced_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head),
    .level     (level)
  );

  assign out_byte      = head.data;
  assign end_of_string = head.eos;
  assign last_of_run   = head.last;

  // The queue never holds more entries than it has.
  assert property (@(posedge clk) disable iff (rst) level <= QCNTW'(QDEPTH))
    else $error("result queue overflow");

  // Results are pushed only when there is room for two.
  assert property (@(posedge clk) disable iff (rst)
                   push.count != 2'd0 |-> $past(room2) || level <= QCNTW'(QDEPTH - 2))
    else $error("push without room");

  // A terminator carries a zero byte and closes its run.
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && end_of_string |-> out_byte == 8'd0 && last_of_run)
    else $error("malformed terminator");

  // Two results from one byte: the first never closes the run.
  assert property (@(posedge clk) disable iff (rst)
                   push.count == 2'd2 |-> !push.r0.last && push.r1.last && !push.r0.eos)
    else $error("bad result pair");

endmodule

// ----- tb/sv/tb_termcap_escape_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_termcap_escape_decoder_unit: self-checking bench of the escape decoder
// Feeds encoded capability string bytes through the input channel, predicts
// the decoded bytes with a scoreboard that tracks the caret, backslash and
// octal modes, and compares every result item with the oldest prediction.
// Both channels idle at random; once the output side holds off long enough
// to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_termcap_escape_decoder_unit
  import tced_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Run shape.
  localparam int ITEM_TARGET    = 1550;
  localparam int IDLE_LIMIT     = 2000;
  localparam int TAIL_CYCLES    = 12;
  localparam int MAX_WAIT       = 12;
  localparam int HOLD_AFTER     = 300;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_OCT_DIGITS = 3;

  // Characters that only the bench needs.
  localparam logic [7:0] DIG_0 = 8'h30;
  localparam logic [7:0] DIG_7 = 8'h37;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       end_of_string;
  logic       last_of_run;

  // Predicts the decoded bytes and checks the block's result items.
  class escape_scoreboard;
    logic [1:0] mode;
    logic [7:0] oct_val;
    logic [1:0] oct_cnt;
    result_t    decoded_q[$];
    result_t    step_q[$];
    int         failures;

    function new();
      clear_escape();
      failures = 0;
    endfunction

    function void clear_escape();
      mode    = MODE_NORMAL;
      oct_val = '0;
      oct_cnt = '0;
    endfunction

    function void emit(logic [7:0] d, logic eos);
      result_t r;
      r.data = d;
      r.eos  = eos;
      r.last = 1'b0;
      step_q.push_back(r);
    endfunction

    // A terminator always leaves the decoder in normal mode.
    function void close_string();
      clear_escape();
      emit(CHR_NUL, 1'b1);
    endfunction

    function void plain_byte(logic [7:0] b);
      if (b == CHR_NUL || b == CHR_COLON) close_string();
      else if (b == CHR_CARET) mode = MODE_CARET;
      else if (b == CHR_BSLASH) mode = MODE_BSLASH;
      else emit(b, 1'b0);
    endfunction

    function bit octal_digit(logic [7:0] b);
      return (b >= DIG_0) && (b <= DIG_7);
    endfunction

    // Letter escapes after a backslash; anything else stands for itself.
    function logic [7:0] letter_code(logic [7:0] b);
      logic [7:0] code;
      case (b)
        "E", "e": code = 8'h1B;
        "s":      code = 8'h20;
        "l", "n": code = 8'h0A;
        "r":      code = 8'h0D;
        "t":      code = 8'h09;
        "a":      code = 8'h07;
        "b":      code = 8'h08;
        "f":      code = 8'h0C;
        "v":      code = 8'h0B;
        default:  code = b;
      endcase
      return code;
    endfunction

    // Decodes one accepted byte and queues the results it completes.
    function void note_input(logic [7:0] b);
      logic [7:0] held;
      result_t    r;
      step_q.delete();
      case (mode)
        MODE_NORMAL: plain_byte(b);
        MODE_CARET: begin
          if (b == CHR_NUL) close_string();
          else begin
            mode = MODE_NORMAL;
            emit((b == CHR_QMARK) ? CHR_DEL : (b & CTRL_MASK), 1'b0);
          end
        end
        MODE_BSLASH: begin
          if (b == CHR_NUL) close_string();
          else if (octal_digit(b)) begin
            mode    = MODE_OCTAL;
            oct_val = {5'b0, b[2:0]};
            oct_cnt = 2'd1;
          end else begin
            mode = MODE_NORMAL;
            emit(letter_code(b), 1'b0);
          end
        end
        default: begin
          if (b == CHR_NUL) close_string();
          else if (octal_digit(b) && oct_cnt < MAX_OCT_DIGITS) begin
            // High bits shift out of the 8-bit value on overflow.
            oct_val = {oct_val[4:0], b[2:0]};
            oct_cnt = oct_cnt + 2'd1;
          end else begin
            held = (oct_val == 8'h00) ? OCT_ZERO : oct_val;
            clear_escape();
            emit(held, 1'b0);
            plain_byte(b);
          end
        end
      endcase
      // Only the final result of this byte carries the run mark.
      foreach (step_q[i]) begin
        r      = step_q[i];
        r.last = (i == step_q.size() - 1);
        decoded_q.push_back(r);
      end
    endfunction

    function void check_result(logic [7:0] d, logic eos, logic last);
      result_t want;
      if (decoded_q.size() == 0) begin
        $error("out_byte: expected no item, actual %02h", d);
        failures++;
        return;
      end
      want = decoded_q.pop_front();
      if (want.data !== d) begin
        $error("out_byte: expected %02h, actual %02h", want.data, d);
        failures++;
      end
      if (want.eos !== eos) begin
        $error("end_of_string: expected %0b, actual %0b", want.eos, eos);
        failures++;
      end
      if (want.last !== last) begin
        $error("last_of_run: expected %0b, actual %0b", want.last, last);
        failures++;
      end
    endfunction
  endclass

  escape_scoreboard sb = new();

  int items_sent = 0;
  bit send_burst = 1'b0;

  termcap_escape_decoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .end_of_string (end_of_string),
    .last_of_run   (last_of_run)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offers one byte after a random gap and waits until it is taken.
  // Valid is only dropped when a gap follows, so back-to-back items keep it high.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (items_sent % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b);
    items_sent++;
  endtask

  // One piece of an encoded string: mostly well-formed escapes, some noise.
  task automatic send_token();
    int         kind;
    int         pick;
    int         ndig;
    logic [7:0] b;
    string      letters;
    letters = "EeslnrtabfvEe:^\\,";
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      send_byte(8'($urandom_range(8'h20, 8'h7E)));
    end else if (kind < 44) begin
      send_byte(CHR_CARET);
      pick = $urandom_range(0, 9);
      if (pick == 0) b = CHR_QMARK;
      else if (pick == 1) b = CHR_NUL;
      else b = 8'($urandom_range(1, 255));
      send_byte(b);
    end else if (kind < 60) begin
      send_byte(CHR_BSLASH);
      pick = $urandom_range(0, 9);
      if (pick == 0) b = CHR_NUL;
      else if (pick < 3) b = 8'($urandom_range(1, 255));
      else b = letters[$urandom_range(0, letters.len() - 1)];
      send_byte(b);
    end else if (kind < 80) begin
      // Octal escape of one to three digits, sometimes with an extra digit.
      send_byte(CHR_BSLASH);
      ndig = $urandom_range(1, MAX_OCT_DIGITS + 1);
      repeat (ndig) send_byte(DIG_0 | 8'($urandom_range(0, 7)));
    end else if (kind < 90) begin
      send_byte($urandom_range(0, 1) ? CHR_COLON : CHR_NUL);
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Stimulus and end of run.
  initial begin
    logic [7:0] intro[$];
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    out_ready = 1'b0;
    // Field extremes, caret and backslash cases, octal value zero, overflow,
    // a fourth digit, a dropped octal value and both terminators.
    intro = '{8'hFF, CHR_CARET, "a", CHR_CARET, CHR_COLON, CHR_CARET, CHR_NUL,
              CHR_BSLASH, "E", CHR_BSLASH, CHR_COLON, CHR_BSLASH, CHR_NUL,
              CHR_BSLASH, "0", CHR_CARET, CHR_QMARK,
              CHR_BSLASH, "7", "7", "7", "7",
              CHR_BSLASH, "1", "2", CHR_NUL, CHR_COLON};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (intro[i]) send_byte(intro[i]);
    while (items_sent < ITEM_TARGET) send_token();
    in_valid <= 1'b0;

    // Drain, then allow for anything the block still emits.
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.failures == 0) begin
      $display("tb_termcap_escape_decoder_unit passed");
    end else begin
      $display("tb_termcap_escape_decoder_unit failed");
    end
    $finish;
  end

  // Result side: random stalls, calm stretches and one long hold-off.
  initial begin
    int stall;
    int seen;
    bit burst;
    bit held;
    seen  = 0;
    burst = 1'b0;
    held  = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (seen % 32 == 0) burst = ($urandom_range(0, 3) == 0);
      if (!held && seen == HOLD_AFTER) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end else begin
        stall = burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_byte, end_of_string, last_of_run);
      seen++;
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("tb_termcap_escape_decoder_unit failed");
    $finish;
  end

endmodule
